// ===== hdl/efla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efla_pkg
// Shared constants for the embedded free list allocator: sizes, widths,
// operation codes, status codes and register indexes.
// ----------------------------------------------------------------------------
package efla_pkg;

    localparam int MAX_BLOCKS = 255;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int OFF_W      = 20;
    localparam int SIZE_W     = 13;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;
    localparam int CNT_W      = 8;
    localparam int DIV_STEPS  = OFF_W;
    localparam int DCNT_W     = $clog2(DIV_STEPS);

    localparam logic [OP_W-1:0] OP_REBUILD  = 3'd0;
    localparam logic [OP_W-1:0] OP_ALLOCATE = 3'd1;
    localparam logic [OP_W-1:0] OP_RELEASE  = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY    = 3'd3;
    localparam logic [OP_W-1:0] OP_CHECK    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_OFFSET = 2'd2;

    localparam logic REG_BLOCK_COUNT = 1'b0;
    localparam logic REG_BLOCK_SIZE  = 1'b1;

endpackage

// ===== hdl/embedded_free_list_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// embedded_free_list_allocator
// Free list allocator over one chunk of equal-size blocks, with the next
// links held in a link memory, plus release, query and integrity check.
// ----------------------------------------------------------------------------
// One transaction is in work at a time; s_ready is high only while the
// sequencer is idle. Release and query first run a 20-step restoring
// divider that turns the byte offset into a block index; a query then
// follows links from the head. Rebuild writes one link per block. When
// link walking is requested, a check first clears the visited map with a
// pass over the configured blocks, then follows links. A full-chunk
// allocate, a zero block size or a zero-count rebuild goes straight to
// the output state. Every link step is one read of the link memory (one
// write port, one read port) plus its registered data; a check step adds
// one read of the visited map. A finished result waits in the output
// register while the next transaction is accepted.
// ----------------------------------------------------------------------------
module embedded_free_list_allocator
    import efla_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [SIZE_W-1:0]   cfg_wdata,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_opcode,
    input  logic [OFF_W-1:0]    s_byte_offset,
    input  logic                s_check_links,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [OFF_W-1:0]    m_block_offset,
    output logic                m_answer,
    output logic [CNT_W-1:0]    m_free_count
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_REBUILD  = 4'd1;
    localparam logic [3:0] S_ALLOC    = 4'd2;
    localparam logic [3:0] S_DIV      = 4'd3;
    localparam logic [3:0] S_POSTDIV  = 4'd4;
    localparam logic [3:0] S_Q_LOOP   = 4'd5;
    localparam logic [3:0] S_Q_CMP    = 4'd6;
    localparam logic [3:0] S_C_LOOP   = 4'd7;
    localparam logic [3:0] S_C_CMP    = 4'd8;
    localparam logic [3:0] S_OUT      = 4'd9;
    localparam logic [3:0] S_C_CLR    = 4'd10;
    localparam logic [3:0] S_C_MARK   = 4'd11;
    localparam logic [3:0] S_C_VIS    = 4'd12;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BLOCKS);

    logic [3:0]            state_reg, state_next;
    logic [OP_W-1:0]       op_reg, op_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]      total_reg, total_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic [SIZE_W-1:0]     rem_reg, rem_next;
    logic [OFF_W-1:0]      quo_reg, quo_next;
    logic [DCNT_W-1:0]     dcnt_reg, dcnt_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [OFF_W-1:0]      res_boff_reg, res_boff_next;
    logic                  res_ans_reg, res_ans_next;
    logic [7:0]            block_count_reg, block_count_next;
    logic [SIZE_W-1:0]     block_size_reg, block_size_next;

    logic                  m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [OFF_W-1:0]      m_boff_reg, m_boff_next;
    logic                  m_ans_reg, m_ans_next;
    logic [CNT_W-1:0]      m_count_reg, m_count_next;

    logic [IDX_W-1:0]      link_mem [0:MAX_BLOCKS-1];
    logic [IDX_W-1:0]      rd_data_reg;
    logic                  mem_we, mem_re;
    logic [IDX_W-1:0]      mem_waddr, mem_wdata, mem_raddr;

    logic                  vis_mem [0:MAX_BLOCKS-1];
    logic                  vis_rd_reg;
    logic                  vis_we, vis_re, vis_wdata;
    logic [IDX_W-1:0]      vis_waddr, vis_raddr;

    logic [SIZE_W:0]       div_trial;
    logic [OFF_W:0]        boff_full;
    logic [IDX_W-1:0]      link_val;

    assign div_trial = {rem_reg, quo_reg[OFF_W-1]};
    assign boff_full = (OFF_W+1)'(head_reg) * (OFF_W+1)'(block_size_reg);
    assign link_val  = (cur_reg == LAST_IDX) ? '0 : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= link_mem[mem_raddr];
        end
    end

    // visited map for the link walk of a check
    always_ff @(posedge aclk) begin
        if (vis_we) begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        if (vis_re) begin
            vis_rd_reg <= vis_mem[vis_raddr];
        end
    end

    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        head_next        = head_reg;
        total_next       = total_reg;
        cnt_next         = cnt_reg;
        cur_next         = cur_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        dcnt_next        = dcnt_reg;
        res_status_next  = res_status_reg;
        res_boff_next    = res_boff_reg;
        res_ans_next     = res_ans_reg;
        block_count_next = block_count_reg;
        block_size_next  = block_size_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_boff_next      = m_boff_reg;
        m_ans_next       = m_ans_reg;
        m_count_next     = m_count_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_waddr        = cnt_reg;
        mem_wdata        = head_reg;
        mem_raddr        = cur_reg;
        vis_we           = 1'b0;
        vis_re           = 1'b0;
        vis_waddr        = cnt_reg;
        vis_wdata        = 1'b0;
        vis_raddr        = rd_data_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_BLOCK_COUNT: block_count_next = cfg_wdata[7:0];
                REG_BLOCK_SIZE:  block_size_next  = cfg_wdata;
                default:         block_count_next = block_count_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next         = s_opcode;
                    res_status_next = ST_OK;
                    res_boff_next   = '0;
                    res_ans_next    = 1'b0;
                    state_next      = S_OUT;
                    unique case (s_opcode)
                        OP_REBUILD: begin
                            head_next  = '0;
                            total_next = block_count_reg;
                            cnt_next   = '0;
                            if (block_count_reg != '0) begin
                                state_next = S_REBUILD;
                            end
                        end
                        OP_ALLOCATE: begin
                            if (total_reg == '0) begin
                                res_status_next = ST_FULL;
                            end else begin
                                res_boff_next = boff_full[OFF_W-1:0];
                                cur_next      = head_reg;
                                mem_raddr     = head_reg;
                                mem_re        = (head_reg != LAST_IDX);
                                state_next    = S_ALLOC;
                            end
                        end
                        OP_RELEASE, OP_QUERY: begin
                            if (block_size_reg == '0) begin
                                res_status_next = ST_BAD_OFFSET;
                            end else begin
                                rem_next   = '0;
                                quo_next   = s_byte_offset;
                                dcnt_next  = '0;
                                state_next = S_DIV;
                            end
                        end
                        OP_CHECK: begin
                            priority if (CNT_W'(block_count_reg) < total_reg) begin
                                res_ans_next = 1'b1;
                            end else if (total_reg == '0) begin
                                res_ans_next = 1'b0;
                            end else if (CNT_W'(head_reg) >= CNT_W'(block_count_reg)) begin
                                res_ans_next = 1'b1;
                            end else if (s_check_links) begin
                                cnt_next   = '0;
                                state_next = S_C_CLR;
                            end else begin
                                res_ans_next = 1'b0;
                            end
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_REBUILD: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = cnt_reg + 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg + 1'b1 == block_count_reg) begin
                    state_next = S_OUT;
                end
            end
            S_ALLOC: begin
                head_next  = link_val;
                total_next = total_reg - 1'b1;
                state_next = S_OUT;
            end
            S_DIV: begin
                if (div_trial >= {1'b0, block_size_reg}) begin
                    rem_next = SIZE_W'(div_trial - {1'b0, block_size_reg});
                    quo_next = {quo_reg[OFF_W-2:0], 1'b1};
                end else begin
                    rem_next = div_trial[SIZE_W-1:0];
                    quo_next = {quo_reg[OFF_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_POSTDIV;
                end
            end
            S_POSTDIV: begin
                state_next = S_OUT;
                if (rem_reg != '0 || quo_reg >= OFF_W'(block_count_reg)) begin
                    res_status_next = ST_BAD_OFFSET;
                end else if (op_reg == OP_RELEASE) begin
                    mem_we    = 1'b1;
                    mem_waddr = quo_reg[IDX_W-1:0];
                    mem_wdata = head_reg;
                    head_next = quo_reg[IDX_W-1:0];
                    if (total_reg != '1) begin
                        total_next = total_reg + 1'b1;
                    end
                end else if (total_reg == '0) begin
                    res_ans_next = 1'b0;
                end else if (head_reg == quo_reg[IDX_W-1:0]) begin
                    res_ans_next = 1'b1;
                end else begin
                    cur_next   = head_reg;
                    cnt_next   = CNT_W'(1);
                    state_next = S_Q_LOOP;
                end
            end
            S_Q_LOOP: begin
                if (cnt_reg >= total_reg) begin
                    state_next = S_OUT;
                end else begin
                    mem_raddr  = cur_reg;
                    mem_re     = (cur_reg != LAST_IDX);
                    state_next = S_Q_CMP;
                end
            end
            S_Q_CMP: begin
                cur_next = link_val;
                if (link_val == quo_reg[IDX_W-1:0]) begin
                    res_ans_next = 1'b1;
                    state_next   = S_OUT;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_Q_LOOP;
                end
            end
            S_C_CLR: begin
                vis_we    = 1'b1;
                vis_waddr = cnt_reg;
                vis_wdata = 1'b0;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg + 1'b1 == block_count_reg) begin
                    state_next = S_C_MARK;
                end
            end
            S_C_MARK: begin
                vis_we     = 1'b1;
                vis_waddr  = head_reg;
                vis_wdata  = 1'b1;
                cnt_next   = CNT_W'(1);
                cur_next   = head_reg;
                state_next = S_C_LOOP;
            end
            S_C_LOOP: begin
                if (cnt_reg >= total_reg) begin
                    state_next = S_OUT;
                end else begin
                    mem_raddr  = cur_reg;
                    mem_re     = 1'b1;
                    state_next = S_C_CMP;
                end
            end
            S_C_CMP: begin
                if (CNT_W'(rd_data_reg) >= CNT_W'(block_count_reg)) begin
                    res_ans_next = 1'b1;
                    state_next   = S_OUT;
                end else begin
                    vis_re     = 1'b1;
                    vis_raddr  = rd_data_reg;
                    cur_next   = rd_data_reg;
                    state_next = S_C_VIS;
                end
            end
            S_C_VIS: begin
                if (vis_rd_reg) begin
                    res_ans_next = 1'b1;
                    state_next   = S_OUT;
                end else begin
                    vis_we     = 1'b1;
                    vis_waddr  = cur_reg;
                    vis_wdata  = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_C_LOOP;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_boff_next   = res_boff_reg;
                    m_ans_next    = res_ans_reg;
                    m_count_next  = total_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            head_reg        <= '0;
            total_reg       <= '0;
            block_count_reg <= 8'd255;
            block_size_reg  <= SIZE_W'(8);
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            total_reg       <= total_next;
            block_count_reg <= block_count_next;
            block_size_reg  <= block_size_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        cnt_reg        <= cnt_next;
        cur_reg        <= cur_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        dcnt_reg       <= dcnt_next;
        res_status_reg <= res_status_next;
        res_boff_reg   <= res_boff_next;
        res_ans_reg    <= res_ans_next;
        m_status_reg   <= m_status_next;
        m_boff_reg     <= m_boff_next;
        m_ans_reg      <= m_ans_next;
        m_count_reg    <= m_count_next;
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_block_offset = m_boff_reg;
    assign m_answer       = m_ans_reg;
    assign m_free_count   = m_count_reg;

endmodule

// ===== tb/sv/free_list_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_checker
// Watches the allocator's configuration, request and result ports. It keeps
// its own copy of the free list (head, free count and next links), works out
// the result of every accepted request transaction and compares each
// accepted result transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module free_list_checker
    import efla_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [SIZE_W-1:0]   cfg_wdata,

    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [OP_W-1:0]     s_opcode,
    input  logic [OFF_W-1:0]    s_byte_offset,
    input  logic                s_check_links,

    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [STATUS_W-1:0] m_status,
    input  logic [OFF_W-1:0]    m_block_offset,
    input  logic                m_answer,
    input  logic [CNT_W-1:0]    m_free_count,

    output int                  fail_count,
    output int                  pending
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFF_W-1:0]    block_offset;
        logic                answer;
        logic [CNT_W-1:0]    free_count;
    } alloc_result_t;

    logic [CNT_W-1:0]  blk_count;
    logic [SIZE_W-1:0] blk_size;
    int                list_head;
    int                list_free;
    logic [IDX_W-1:0]  link_mem [MAX_BLOCKS];
    logic              seen     [MAX_BLOCKS];
    alloc_result_t     expected_q [$];

    function automatic int used_blocks();
        return (blk_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(blk_count);
    endfunction

    function automatic int link_at(input int idx);
        if (idx < MAX_BLOCKS) return int'(link_mem[idx]);
        return 0;
    endfunction

    function automatic logic offset_to_block(input logic [OFF_W-1:0] off, output int idx);
        int o;
        int s;
        o   = int'(off);
        s   = int'(blk_size);
        idx = 0;
        if (s == 0 || o % s != 0 || o / s >= used_blocks()) return 1'b0;
        idx = o / s;
        return 1'b1;
    endfunction

    function automatic logic list_corrupt(input logic walk);
        int   nb;
        int   index;
        int   steps;
        logic corrupt;
        nb = used_blocks();
        if (nb < list_free) return 1'b1;
        if (list_free == 0) return 1'b0;
        if (list_head >= nb) return 1'b1;
        if (!walk) return 1'b0;
        foreach (seen[k]) seen[k] = 1'b0;
        corrupt     = 1'b0;
        index       = list_head;
        seen[index] = 1'b1;
        steps       = 1;
        while (!corrupt && steps < list_free) begin
            index = link_at(index);
            if (index >= nb || seen[index]) begin
                corrupt = 1'b1;
            end else begin
                seen[index] = 1'b1;
                steps++;
            end
        end
        return corrupt;
    endfunction

    function automatic alloc_result_t predict_alloc_result(input logic [OP_W-1:0] op,
                                                           input logic [OFF_W-1:0] off,
                                                           input logic walk);
        alloc_result_t r;
        int            idx;
        int            nb;
        int            cur;
        int            k;
        int            prod;
        r = '0;
        case (op)
            OP_REBUILD: begin
                nb = used_blocks();
                for (k = 0; k < nb; k++) link_mem[k] = IDX_W'(k + 1);
                list_head = 0;
                list_free = nb;
            end
            OP_ALLOCATE: begin
                if (list_free == 0) begin
                    r.status = ST_FULL;
                end else begin
                    prod           = list_head * int'(blk_size);
                    r.block_offset = prod[OFF_W-1:0];
                    list_head      = link_at(list_head) & 8'hFF;
                    list_free--;
                end
            end
            OP_RELEASE: begin
                if (!offset_to_block(off, idx)) begin
                    r.status = ST_BAD_OFFSET;
                end else begin
                    link_mem[idx] = IDX_W'(list_head);
                    list_head     = idx;
                    if (list_free < 255) list_free++;
                end
            end
            OP_QUERY: begin
                if (!offset_to_block(off, idx)) begin
                    r.status = ST_BAD_OFFSET;
                end else if (list_free != 0) begin
                    cur      = list_head;
                    r.answer = (cur == idx);
                    for (k = 1; k < list_free && !r.answer; k++) begin
                        cur      = link_at(cur);
                        r.answer = (cur == idx);
                    end
                end
            end
            OP_CHECK: begin
                r.answer = list_corrupt(walk);
            end
            default: begin
            end
        endcase
        r.free_count = list_free[CNT_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        alloc_result_t exp_r;
        if (!aresetn) begin
            blk_count = CNT_W'(MAX_BLOCKS);
            blk_size  = SIZE_W'(8);
            list_head = 0;
            list_free = 0;
            foreach (link_mem[k]) link_mem[k] = '0;
            expected_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_BLOCK_COUNT) begin
                    blk_count = cfg_wdata[CNT_W-1:0];
                end else begin
                    blk_size = cfg_wdata;
                end
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result transaction with no expected result");
                    fail_count++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (m_status !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, m_status);
                        fail_count++;
                    end
                    if (m_block_offset !== exp_r.block_offset) begin
                        $error("block_offset: expected %0d, got %0d",
                               exp_r.block_offset, m_block_offset);
                        fail_count++;
                    end
                    if (m_answer !== exp_r.answer) begin
                        $error("answer: expected %0d, got %0d", exp_r.answer, m_answer);
                        fail_count++;
                    end
                    if (m_free_count !== exp_r.free_count) begin
                        $error("free_count: expected %0d, got %0d",
                               exp_r.free_count, m_free_count);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_q.push_back(predict_alloc_result(s_opcode, s_byte_offset,
                                                          s_check_links));
            end
        end
        pending = expected_q.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the free list allocator: directed corner cases, then phases
// of random traffic of all opcodes over several chunk configurations with
// varying handshake idling. Checking is done by free_list_checker.
// ----------------------------------------------------------------------------
module tb_top
    import efla_pkg::*;
();

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TAIL_CYCLES     = 600;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 150;

    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                cfg_wr_en     = 1'b0;
    logic                cfg_index     = 1'b0;
    logic [SIZE_W-1:0]   cfg_wdata     = '0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_opcode      = '0;
    logic [OFF_W-1:0]    s_byte_offset = '0;
    logic                s_check_links = 1'b0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [OFF_W-1:0]    m_block_offset;
    logic                m_answer;
    logic [CNT_W-1:0]    m_free_count;

    int                  fail_count;
    int                  pending_results;
    idle_mode_e          idle_mode     = IDLE_NONE;
    int                  hold_requests = 0;
    int                  idle_cycles   = 0;

    logic [OP_W-1:0]     issued_ops [$];
    logic [OFF_W-1:0]    alloc_log [$];
    logic [OFF_W-1:0]    release_pool [$];
    int                  pool_seen = 0;

    int phase_counts [PHASES] = '{255, 1, 255, 2, 255, 16, 0, 255, 100, 7, 255, 255};
    int phase_sizes  [PHASES] = '{8, 1, 8191, 4096, 1, 3, 5, 0, 12, 8191, 4096, 64};

    always #5 aclk = ~aclk;

    embedded_free_list_allocator uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_byte_offset  (s_byte_offset),
        .s_check_links  (s_check_links),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_block_offset (m_block_offset),
        .m_answer       (m_answer),
        .m_free_count   (m_free_count)
    );

    free_list_checker result_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_byte_offset  (s_byte_offset),
        .s_check_links  (s_check_links),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_block_offset (m_block_offset),
        .m_answer       (m_answer),
        .m_free_count   (m_free_count),
        .fail_count     (fail_count),
        .pending        (pending_results)
    );

    // offsets handed out by allocate, reused as release targets
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready && issued_ops.size() > 0) begin
                if (issued_ops.pop_front() == OP_ALLOCATE && m_status == ST_OK) begin
                    alloc_log.push_back(m_block_offset);
                end
            end
            if (s_valid && s_ready) issued_ops.push_back(s_opcode);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic logic sender_rests();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(99) < 63;
            IDLE_BOTH:   return $urandom_range(99) < 16;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic logic receiver_stalls();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(99) < 63;
            IDLE_BOTH:     return $urandom_range(99) < 16;
            default:       return 1'b0;
        endcase
    endfunction

    initial begin : receiver
        int holds_served;
        int k;
        holds_served = 0;
        forever begin
            @(negedge aclk);
            if (hold_requests != holds_served) begin
                holds_served++;
                m_ready = 1'b0;
                for (k = 0; k < HOLD_OFF_CYCLES; k++) @(negedge aclk);
            end else begin
                m_ready = !receiver_stalls();
            end
        end
    end

    function automatic logic [OFF_W-1:0] rand_offset();
        logic [31:0] v;
        v = $urandom;
        return v[OFF_W-1:0];
    endfunction

    function automatic logic [OFF_W-1:0] pick_offset(input int nb, input int bsize);
        int pick;
        int idx;
        int v;
        pick = $urandom_range(99);
        idx  = (nb > 0) ? $urandom_range(nb - 1) : 0;
        if (bsize == 0 || pick < 10) begin
            v = $urandom;
        end else if (pick < 18) begin
            v = (nb + $urandom_range(3)) * bsize;
        end else if (pick < 26 && bsize > 1) begin
            v = idx * bsize + $urandom_range(bsize - 1, 1);
        end else begin
            v = idx * bsize;
        end
        return v[OFF_W-1:0];
    endfunction

    task automatic send_op(input logic [OP_W-1:0] op, input logic [OFF_W-1:0] off,
                           input logic walk);
        @(negedge aclk);
        while (sender_rests()) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_opcode      = op;
        s_byte_offset = off;
        s_check_links = walk;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_results != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [SIZE_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic send_random_op(input int nb, input int bsize);
        int               r;
        int               pick;
        logic             walk;
        logic [OP_W-1:0]  spare;
        logic [OFF_W-1:0] off;
        while (pool_seen < alloc_log.size()) begin
            release_pool.push_back(alloc_log[pool_seen]);
            pool_seen++;
        end
        r    = $urandom_range(99);
        walk = 1'($urandom_range(1));
        if (r < 4) begin
            send_op(OP_REBUILD, rand_offset(), walk);
        end else if (r < 38) begin
            send_op(OP_ALLOCATE, rand_offset(), walk);
        end else if (r < 70) begin
            if (release_pool.size() > 0 && $urandom_range(99) < 55) begin
                pick = $urandom_range(release_pool.size() - 1);
                off  = release_pool[pick];
                release_pool.delete(pick);
            end else begin
                off = pick_offset(nb, bsize);
            end
            send_op(OP_RELEASE, off, walk);
        end else if (r < 84) begin
            send_op(OP_QUERY, pick_offset(nb, bsize), walk);
        end else if (r < 96) begin
            send_op(OP_CHECK, rand_offset(), walk);
        end else begin
            case ($urandom_range(2))
                0:       spare = OP_SPARE_A;
                1:       spare = OP_SPARE_B;
                default: spare = OP_SPARE_C;
            endcase
            send_op(spare, rand_offset(), walk);
        end
    endtask

    initial begin : stimulus
        int ph;
        int n;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty chunk after reset, repeated release, bad offsets, spare opcodes
        idle_mode = IDLE_BOTH;
        send_op(OP_ALLOCATE, '0, 1'b0);
        send_op(OP_QUERY, '0, 1'b0);
        send_op(OP_CHECK, '0, 1'b1);
        send_op(OP_RELEASE, '0, 1'b0);
        send_op(OP_RELEASE, '0, 1'b1);
        send_op(OP_CHECK, '0, 1'b1);
        send_op(OP_CHECK, '1, 1'b0);
        send_op(OP_RELEASE, 20'd3, 1'b0);
        send_op(OP_RELEASE, 20'd2040, 1'b0);
        send_op(OP_QUERY, '1, 1'b1);
        send_op(OP_SPARE_A, rand_offset(), 1'b1);
        send_op(OP_SPARE_B, rand_offset(), 1'b0);
        send_op(OP_SPARE_C, '1, 1'b1);
        // full list, deep query, free count saturation
        send_op(OP_REBUILD, '1, 1'b1);
        send_op(OP_QUERY, 20'd2032, 1'b0);
        send_op(OP_CHECK, '0, 1'b1);
        send_op(OP_ALLOCATE, '0, 1'b0);
        send_op(OP_RELEASE, 20'd8, 1'b0);
        send_op(OP_RELEASE, 20'd16, 1'b0);
        // zero block count
        drain();
        write_reg(REG_BLOCK_COUNT, SIZE_W'(0));
        send_op(OP_REBUILD, '0, 1'b0);
        send_op(OP_ALLOCATE, '0, 1'b0);
        send_op(OP_CHECK, '0, 1'b1);
        // zero block size
        drain();
        write_reg(REG_BLOCK_COUNT, SIZE_W'(1));
        write_reg(REG_BLOCK_SIZE, SIZE_W'(0));
        send_op(OP_REBUILD, '0, 1'b0);
        send_op(OP_ALLOCATE, '0, 1'b0);
        send_op(OP_RELEASE, '0, 1'b0);
        send_op(OP_QUERY, '0, 1'b0);

        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            idle_mode = idle_mode_e'(ph % 4);
            write_reg(REG_BLOCK_COUNT, SIZE_W'(phase_counts[ph]));
            write_reg(REG_BLOCK_SIZE, SIZE_W'(phase_sizes[ph]));
            pool_seen = alloc_log.size();
            release_pool.delete();
            send_op(OP_REBUILD, '0, 1'b0);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph % 4 == 0 && n == 40) hold_requests++;
                if (ph % 4 == 0 && n == 100) drain();
                send_random_op(phase_counts[ph], phase_sizes[ph]);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
